@@ rtl/scdma_pkg.sv @@
`timescale 1ns / 1ps

package scdma_pkg;

    // Channel selected by the action field.
    localparam logic CH_FROM_SPR = 1'b0;
    localparam logic CH_TO_SPR   = 1'b1;

    // Channel modes, control bits 3:2.
    localparam logic [1:0] MODE_NORMAL     = 2'd0;
    localparam logic [1:0] MODE_CHAIN      = 2'd1;
    localparam logic [1:0] MODE_INTERLEAVE = 2'd2;
    localparam logic [1:0] MODE_NONE       = 2'd3;

    // Control register bit positions.
    localparam int unsigned CHCR_TTE_BIT = 6;
    localparam int unsigned CHCR_TIE_BIT = 7;
    localparam int unsigned CHCR_STR_BIT = 8;

    // Tag IDs.
    localparam logic [2:0] TAG_REFE = 3'd0;
    localparam logic [2:0] TAG_CNT  = 3'd1;
    localparam logic [2:0] TAG_NEXT = 3'd2;
    localparam logic [2:0] TAG_REF  = 3'd3;
    localparam logic [2:0] TAG_REFS = 3'd4;
    localparam logic [2:0] TAG_CALL = 3'd5;
    localparam logic [2:0] TAG_RET  = 3'd6;
    localparam logic [2:0] TAG_END  = 3'd7;

    // Address translation constants.
    localparam logic [31:0] SCR_BASE      = 32'h7000_0000;
    localparam logic [31:0] BUS_ADDR_MASK = 32'h7FFF_FFF0;

    localparam int unsigned SADR_W  = 14;
    localparam int unsigned COUNT_W = 11;

    typedef struct packed {
        logic              action;
        logic [31:0]       chcr;
        logic [31:0]       madr;
        logic [15:0]       qwc;
        logic [31:0]       tadr;
        logic [SADR_W-1:0] sadr;
        logic [63:0]       tag_word;
    } t_in_item;

    typedef struct packed {
        logic [31:0]        new_madr;
        logic [15:0]        new_qwc;
        logic [31:0]        new_tadr;
        logic [SADR_W-1:0]  new_sadr;
        logic [31:0]        new_chcr;
        logic [COUNT_W-1:0] copy_count;
        logic [31:0]        copy_src;
        logic [31:0]        copy_dst;
        logic               tag_write;
        logic               tag_used;
        logic               channel_done;
        logic               written_back;
    } t_out_item;

    // Update of one channel's pending-end bit.
    typedef struct packed {
        logic we;
        logic value;
    } t_pend_upd;

endpackage

@@ rtl/scdma_step.sv @@
`timescale 1ns / 1ps

module scdma_step
    import scdma_pkg::*;
#(
    parameter int unsigned MAX_CHUNK         = 1024,
    parameter int unsigned SCRATCH_ADDR_BITS = 14
) (
    input  t_in_item  i_item,
    input  logic      i_dmac_en,
    input  logic      i_pend_cur,
    output t_out_item o_result,
    output t_pend_upd o_pend_upd
);

    localparam int unsigned SW = SCRATCH_ADDR_BITS;
    localparam logic [31:0] ScrMask   = 32'((64'd1 << SW) - 64'd1);
    localparam logic [15:0] MaxChunk  = 16'(MAX_CHUNK);
    localparam logic [SW-1:0] SadrStep = SW'(16);

    function automatic logic [31:0] map_bus(input logic [31:0] v);
        logic [31:0] r;
        if (v[31]) begin
            r = SCR_BASE | (v & ScrMask);
        end else begin
            r = v & BUS_ADDR_MASK;
        end
        return r;
    endfunction

    function automatic logic [31:0] map_scr(input logic [SW-1:0] s);
        logic [SW+31:0] ext;
        ext = {32'd0, s};
        return SCR_BASE | ext[31:0];
    endfunction

    logic [1:0]      mode;
    logic            active;
    logic            fetch;
    logic [31:0]     t0, t1;
    logic [2:0]      tag_id;
    logic [SW+13:0]  sadr_ext;
    logic [SW-1:0]   sadr_in;
    logic [31:0]     tag_taddr, tag_addr, tag_after;
    logic [15:0]     qwc_a;
    logic [31:0]     chcr_a, madr_a, tadr_a;
    logic [SW-1:0]   sadr_a;
    logic            end_a, pend_a, twrite;
    logic [15:0]     chunk;
    logic [31:0]     chunk_bytes;
    logic [31:0]     madr_b, src, dst;
    logic [SW-1:0]   sadr_b;
    logic [15:0]     qwc_b;
    logic            pend_b, done;
    logic [SW+13:0]  sadr_out_ext;
    logic [SW+13:0]  sadr_echo_ext;

    assign mode     = i_item.chcr[3:2];
    assign active   = i_dmac_en && i_item.chcr[CHCR_STR_BIT] && (mode != MODE_NONE);
    assign fetch    = (mode == MODE_CHAIN) && (i_item.qwc == 16'd0) && !i_pend_cur;
    assign t0       = i_item.tag_word[31:0];
    assign t1       = i_item.tag_word[63:32];
    assign tag_id   = t0[30:28];
    assign sadr_ext = {{SW{1'b0}}, i_item.sadr};
    assign sadr_in  = sadr_ext[SW-1:0];

    assign tag_taddr = map_bus(i_item.tadr);
    assign tag_addr  = map_bus(t1);
    assign tag_after = tag_taddr + 32'd16;

    // Tag fetch and decode.
    always_comb begin
        qwc_a  = i_item.qwc;
        chcr_a = i_item.chcr;
        madr_a = i_item.madr;
        tadr_a = i_item.tadr;
        sadr_a = sadr_in;
        end_a  = 1'b0;
        twrite = 1'b0;
        pend_a = i_pend_cur;
        if (fetch) begin
            qwc_a  = t0[15:0];
            chcr_a = {t0[31:16], i_item.chcr[15:0]};
            end_a  = t0[31] && i_item.chcr[CHCR_TIE_BIT];
            if (i_item.action == CH_FROM_SPR) begin
                sadr_a = sadr_in + SadrStep;
                madr_a = tag_addr;
                if (tag_id != TAG_REFE && tag_id != TAG_CNT) begin
                    end_a = 1'b1;
                end
            end else begin
                if (tag_id == TAG_REFE || tag_id == TAG_END) begin
                    end_a = 1'b1;
                end
                unique case (tag_id)
                    TAG_REFE, TAG_REF, TAG_REFS: begin
                        madr_a = tag_addr;
                        tadr_a = tag_after;
                    end
                    TAG_CNT, TAG_END: begin
                        madr_a = tag_after;
                        tadr_a = tag_after + {12'd0, t0[15:0], 4'd0};
                    end
                    TAG_CALL, TAG_RET: begin
                        end_a  = 1'b1;
                        madr_a = tag_after;
                        tadr_a = tag_addr;
                    end
                    TAG_NEXT: begin
                        madr_a = tag_after;
                        tadr_a = tag_addr;
                    end
                endcase
                if (i_item.chcr[CHCR_TTE_BIT]) begin
                    twrite = 1'b1;
                    sadr_a = sadr_in + SadrStep;
                end
            end
            pend_a = end_a;
        end
    end

    // Copy command for up to one chunk.
    always_comb begin
        chunk       = 16'd0;
        src         = 32'd0;
        dst         = 32'd0;
        madr_b      = madr_a;
        sadr_b      = sadr_a;
        qwc_b       = qwc_a;
        chunk_bytes = 32'd0;
        if (qwc_a != 16'd0) begin
            chunk       = (qwc_a < MaxChunk) ? qwc_a : MaxChunk;
            chunk_bytes = {12'd0, chunk, 4'd0};
            if (i_item.action == CH_FROM_SPR) begin
                src = map_scr(sadr_a);
                dst = map_bus(madr_a);
            end else begin
                src = map_bus(madr_a);
                dst = map_scr(sadr_a);
            end
            madr_b = madr_a + chunk_bytes;
            sadr_b = sadr_a + chunk_bytes[SW-1:0];
            qwc_b  = qwc_a - chunk;
        end
    end

    assign pend_b        = ((mode != MODE_CHAIN) && (qwc_b == 16'd0)) ? 1'b1 : pend_a;
    assign done          = (qwc_b == 16'd0) && pend_b;
    assign sadr_out_ext  = {14'd0, sadr_b};
    assign sadr_echo_ext = {14'd0, sadr_in};

    always_comb begin
        o_result.new_madr     = i_item.madr;
        o_result.new_qwc      = i_item.qwc;
        o_result.new_tadr     = i_item.tadr;
        o_result.new_chcr     = i_item.chcr;
        o_result.copy_count   = '0;
        o_result.copy_src     = '0;
        o_result.copy_dst     = '0;
        o_result.tag_write    = 1'b0;
        o_result.tag_used     = 1'b0;
        o_result.channel_done = 1'b0;
        o_result.written_back = 1'b0;
        o_pend_upd.we         = 1'b0;
        o_pend_upd.value      = 1'b0;
        // Idle echo keeps only the scratchpad address bits that are in range.
        o_result.new_sadr     = sadr_echo_ext[SADR_W-1:0];
        if (active) begin
            o_result.new_madr     = madr_b;
            o_result.new_qwc      = qwc_b;
            o_result.new_tadr     = tadr_a;
            o_result.new_sadr     = sadr_out_ext[SADR_W-1:0];
            o_result.new_chcr     = done ? (chcr_a & ~(32'd1 << CHCR_STR_BIT)) : chcr_a;
            o_result.copy_count   = chunk[COUNT_W-1:0];
            o_result.copy_src     = src;
            o_result.copy_dst     = dst;
            o_result.tag_write    = twrite;
            o_result.tag_used     = fetch;
            o_result.channel_done = done;
            o_result.written_back = 1'b1;
            o_pend_upd.we         = 1'b1;
            o_pend_upd.value      = pend_b && !done;
        end
    end

endmodule

@@ rtl/scratchpad_dma_channel_step.sv @@
`timescale 1ns / 1ps

// Scratchpad DMA channel service step. Each input beat carries one channel's
// registers (control, memory address, quadword count, tag address, scratchpad
// address) plus the tag word at its current tag address; each output beat
// carries the updated registers and one copy command for the separate mover
// (count, first source and destination address, and whether the tag quadword
// goes to the scratchpad first), along with the done flag that raises the
// channel interrupt. Chain mode fetches and decodes a tag when the count is
// zero and no end is pending; normal, interleave and chain modes move up to
// MAX_CHUNK quadwords a step. The block keeps one pending-end bit per channel,
// cleared by reset, and the global enable written through the configuration
// port (write it only while no beat is in flight). Each beat passes from
// acceptance through the input register, where the decode, the address
// updates and the read-modify-write of the pending-end bit happen, and then
// the output register. One beat is accepted every cycle unless the input
// stalls; a stalled output holds its beat while the input register still
// takes one more, and the input stalls only when both registers are full.
// SCRATCH_ADDR_BITS sets the scratchpad address wrap; the scratchpad address
// fields on the ports stay 14 bits wide.

module scratchpad_dma_channel_step
    import scdma_pkg::*;
#(
    parameter int unsigned MAX_CHUNK         = 1024,
    parameter int unsigned SCRATCH_ADDR_BITS = 14
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_data,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    logic      r_dmac_en;
    logic [1:0] r_end_pend;
    logic      r_s1_valid;
    t_in_item  r_s1_item;
    logic      r_out_valid;
    t_out_item r_out;

    logic      advance;
    logic      s1_load;
    logic      pend_cur;
    t_out_item step_result;
    t_pend_upd pend_upd;

    // The output register can take a new beat when it is empty or being
    // drained this cycle; the input register refills whenever it moves on.
    assign advance    = !r_out_valid || !i_out_stall;
    assign s1_load    = !r_s1_valid || advance;
    assign o_in_stall = !s1_load;

    assign pend_cur = r_end_pend[r_s1_item.action];

    scdma_step #(
        .MAX_CHUNK         (MAX_CHUNK),
        .SCRATCH_ADDR_BITS (SCRATCH_ADDR_BITS)
    ) u_step (
        .i_item     (r_s1_item),
        .i_dmac_en  (r_dmac_en),
        .i_pend_cur (pend_cur),
        .o_result   (step_result),
        .o_pend_upd (pend_upd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dmac_en   <= 1'b0;
            r_end_pend  <= 2'b00;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_dmac_en <= i_cfg_data;
            end
            if (s1_load) begin
                r_s1_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_s1_valid;
                // The pending-end bit is committed as the beat leaves the input
                // register, so a beat right behind it on the same channel sees it.
                if (r_s1_valid && pend_upd.we) begin
                    r_end_pend[r_s1_item.action] <= pend_upd.value;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load && i_in_valid) begin
            r_s1_item <= i_in;
        end
        if (advance && r_s1_valid) begin
            r_out <= step_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

@@ sim/tb_scratchpad_dma_channel_step.sv @@
`timescale 1ns / 1ps

module tb_scratchpad_dma_channel_step;
    import scdma_pkg::*;

    // The block is built with its default sizes, and the predictor uses the same ones.
    localparam int unsigned MAX_CHUNK         = 1024;
    localparam int unsigned SCRATCH_ADDR_BITS = 14;
    localparam logic [31:0] SPR_MASK          = (32'd1 << SCRATCH_ADDR_BITS) - 32'd1;

    // The watchdog limit is far above the slowest legal run.
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned HOLD_CYCLES  = 60;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned PRINT_LIMIT  = 100;

    logic      i_clk;
    logic      i_rst_n   = 1'b0;
    logic      cfg_we    = 1'b0;
    logic      cfg_data  = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_beat   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_beat;

    // These knobs shape the traffic. The test tasks set them between phases.
    int unsigned idle_pct       = 0;
    int unsigned stall_pct      = 0;
    logic        hold_armed     = 1'b0;
    logic        hold_active    = 1'b0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    // The predictor keeps its own copy of the enable and of the pending-end bit of
    // each channel. It also keeps the last predicted registers of each channel, so
    // that random traffic can carry a chain transfer on from one step to the next.
    bit          dmac_en;
    bit          end_pend [2];
    t_in_item    chan_regs [2];
    t_out_item   predicted_steps [$];

    scratchpad_dma_channel_step #(
        .MAX_CHUNK        (MAX_CHUNK),
        .SCRATCH_ADDR_BITS(SCRATCH_ADDR_BITS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in       (in_beat),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out      (out_beat)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // A bus address with bit 31 set maps into the scratchpad window. Any other bus
    // address is aligned to a quadword and loses bit 31.
    function automatic logic [31:0] bus_xlate(input logic [31:0] addr);
        if (addr[31]) begin
            return SCR_BASE | (addr & SPR_MASK);
        end
        return addr & BUS_ADDR_MASK;
    endfunction

    // This function serves one channel for one step. It updates the pending-end
    // bits as the block does and returns the beat that the block should produce.
    function automatic t_out_item serve_channel(input t_in_item it);
        t_out_item   r;
        logic        ch;
        logic [31:0] cr, ma, ta, sa, q, cnt;
        logic [31:0] t0, t1, taddr, naddr, after;
        logic [1:0]  md;
        logic [2:0]  id;
        logic        fin;

        ch = it.action;
        cr = it.chcr;
        ma = it.madr;
        ta = it.tadr;
        q  = {16'h0, it.qwc};
        sa = {18'h0, it.sadr} & SPR_MASK;
        md = cr[3:2];

        // An idle step echoes the registers and leaves every other field at zero.
        r = '0;
        r.new_madr = ma;
        r.new_qwc  = q[15:0];
        r.new_tadr = ta;
        r.new_sadr = sa[SADR_W-1:0];
        r.new_chcr = cr;
        if (!dmac_en || !cr[CHCR_STR_BIT] || md == MODE_NONE) begin
            return r;
        end

        // Chain mode fetches a tag when the count is zero and no end is pending.
        if (md == MODE_CHAIN && q == 32'd0 && !end_pend[ch]) begin
            t0 = it.tag_word[31:0];
            t1 = it.tag_word[63:32];
            id = t0[30:28];
            r.tag_used = 1'b1;
            q   = {16'h0, t0[15:0]};
            cr  = {t0[31:16], cr[15:0]};
            fin = t0[31] && cr[CHCR_TIE_BIT];
            if (ch == CH_FROM_SPR) begin
                // The from channel skips the tag quadword in the scratchpad. Every
                // ID except REFE and CNT ends the chain, and tag transfer is ignored.
                sa = (sa + 32'd16) & SPR_MASK;
                ma = bus_xlate(t1);
                if (id != TAG_REFE && id != TAG_CNT) begin
                    fin = 1'b1;
                end
            end else begin
                taddr = bus_xlate(ta);
                naddr = bus_xlate(t1);
                after = taddr + 32'd16;
                case (id)
                    TAG_REFE, TAG_REF, TAG_REFS: begin
                        ma = naddr;
                        ta = after;
                    end
                    TAG_CNT, TAG_END: begin
                        ma = after;
                        ta = after + q * 32'd16;
                    end
                    TAG_CALL, TAG_RET: begin
                        // Call and return work as NEXT and also end the chain.
                        fin = 1'b1;
                        ma  = after;
                        ta  = naddr;
                    end
                    default: begin
                        ma = after;
                        ta = naddr;
                    end
                endcase
                if (id == TAG_REFE || id == TAG_END) begin
                    fin = 1'b1;
                end
                if (cr[CHCR_TTE_BIT]) begin
                    r.tag_write = 1'b1;
                    sa = (sa + 32'd16) & SPR_MASK;
                end
            end
            end_pend[ch] = fin;
        end

        // One chunk of at most MAX_CHUNK quadwords moves per step.
        if (q != 32'd0) begin
            cnt = (q < MAX_CHUNK) ? q : MAX_CHUNK;
            if (ch == CH_FROM_SPR) begin
                r.copy_src = SCR_BASE | (sa & SPR_MASK);
                r.copy_dst = bus_xlate(ma);
            end else begin
                r.copy_src = bus_xlate(ma);
                r.copy_dst = SCR_BASE | (sa & SPR_MASK);
            end
            r.copy_count = cnt[COUNT_W-1:0];
            ma = ma + cnt * 32'd16;
            sa = (sa + cnt * 32'd16) & SPR_MASK;
            q  = q - cnt;
        end
        if (md != MODE_CHAIN && q == 32'd0) begin
            end_pend[ch] = 1'b1;
        end
        if (q == 32'd0 && end_pend[ch]) begin
            end_pend[ch]      = 1'b0;
            cr[CHCR_STR_BIT]  = 1'b0;
            r.channel_done    = 1'b1;
        end

        r.new_madr     = ma;
        r.new_qwc      = q[15:0];
        r.new_tadr     = ta;
        r.new_sadr     = sa[SADR_W-1:0];
        r.new_chcr     = cr;
        r.written_back = 1'b1;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Beat builders
    // ------------------------------------------------------------------

    function automatic logic [31:0] ctl_word(input logic [1:0] mode, input logic tte,
                                             input logic tie, input logic str);
        logic [31:0] w;
        w = '0;
        w[3:2]         = mode;
        w[CHCR_TTE_BIT] = tte;
        w[CHCR_TIE_BIT] = tie;
        w[CHCR_STR_BIT] = str;
        return w;
    endfunction

    // The tag is laid out as address, IRQ, ID, twelve spare bits and the count.
    function automatic logic [63:0] mk_tag(input logic irq, input logic [2:0] id,
                                           input logic [15:0] count, input logic [31:0] addr);
        return {addr, irq, id, 12'h0, count};
    endfunction

    function automatic t_in_item mk_beat(input logic ch, input logic [31:0] chcr,
                                         input logic [31:0] madr, input logic [15:0] qwc,
                                         input logic [31:0] tadr, input logic [SADR_W-1:0] sadr,
                                         input logic [63:0] tag);
        t_in_item it;
        it.action   = ch;
        it.chcr     = chcr;
        it.madr     = madr;
        it.qwc      = qwc;
        it.tadr     = tadr;
        it.sadr     = sadr;
        it.tag_word = tag;
        return it;
    endfunction

    // Most tags carry short counts, so that chains end within a few steps. Now and
    // then a tag carries a full random count.
    function automatic logic [63:0] random_tag();
        logic [31:0] lo;
        logic [31:0] hi;
        lo = $urandom;
        hi = $urandom;
        if ($urandom_range(9) != 0) begin
            lo[15:0] = 16'($urandom_range(40));
        end
        return {hi, lo};
    endfunction

    // Most beats carry on a channel whose transfer is still running. Some start a
    // fresh transfer that is well formed, and the rest are plain noise.
    function automatic t_in_item random_beat();
        t_in_item    it;
        logic        ch;
        int unsigned pick;
        ch   = 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < 65 && chan_regs[ch].chcr[CHCR_STR_BIT]) begin
            it = chan_regs[ch];
        end else if (pick < 88) begin
            it.chcr               = $urandom;
            it.chcr[3:2]          = 2'($urandom_range(2));
            it.chcr[CHCR_STR_BIT] = 1'b1;
            it.madr               = $urandom;
            it.tadr               = $urandom;
            it.sadr               = SADR_W'($urandom_range(SPR_MASK));
            if (it.chcr[3:2] == MODE_CHAIN && $urandom_range(3) != 0) begin
                it.qwc = 16'd0;
            end else begin
                it.qwc = 16'($urandom_range(2100));
            end
        end else begin
            it.chcr = $urandom;
            it.madr = $urandom;
            it.tadr = $urandom;
            it.qwc  = 16'($urandom_range(16'hFFFF));
            it.sadr = SADR_W'($urandom_range(SPR_MASK));
        end
        it.action   = ch;
        it.tag_word = random_tag();
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // This task offers one beat and waits until the block takes it. Valid stays
    // high after the beat is taken, so that the next call can either keep it high
    // or drop it for an idle gap. In each case there is one assignment per edge.
    task automatic send_beat(input t_in_item it);
        t_out_item want;
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_beat  <= it;
        @(posedge i_clk);
        while (in_stall) begin
            @(posedge i_clk);
        end
        want = serve_channel(it);
        predicted_steps.push_back(want);
        chan_regs[it.action].chcr = want.new_chcr;
        chan_regs[it.action].madr = want.new_madr;
        chan_regs[it.action].qwc  = want.new_qwc;
        chan_regs[it.action].tadr = want.new_tadr;
        chan_regs[it.action].sadr = want.new_sadr;
    endtask

    // Every beat produces exactly one result. The block is idle once every
    // predicted step has come back, and a short margin covers its two-stage pipe.
    task automatic settle();
        in_valid <= 1'b0;
        while (predicted_steps.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_dmac_enable(input logic value);
        settle();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        dmac_en   = value;
    endtask

    task automatic run_random(input int unsigned count, input int unsigned src_idle,
                              input int unsigned sink_stall);
        idle_pct  = src_idle;
        stall_pct = sink_stall;
        repeat (count) send_beat(random_beat());
        settle();
    endtask

    // ------------------------------------------------------------------
    // Receiver side
    // ------------------------------------------------------------------

    // While a long hold runs, the receiver stalls every cycle. Otherwise it stalls
    // at random with the chance that the current phase sets.
    always @(posedge i_clk) begin
        if (hold_active) begin
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // The long hold counts its own cycles, so that the sender keeps offering beats
    // until the block has filled up and stalled its input.
    initial begin : long_hold
        forever begin
            wait (hold_armed);
            @(posedge i_clk);
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_active <= 1'b0;
            hold_armed   = 1'b0;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("MISMATCH at %0t ns: %s got %h, want %h", $time, what, got, want);
        end
        mismatch_count++;
    endtask

    task automatic compare_field(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    // Each beat that the receiver takes is checked against the oldest predicted step.
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (predicted_steps.size() == 0) begin
                report_mismatch("beat with no step pending, new_madr",
                                64'(out_beat.new_madr), '0);
            end else begin
                want = predicted_steps.pop_front();
                compare_field("new_madr",     64'(out_beat.new_madr),     64'(want.new_madr));
                compare_field("new_qwc",      64'(out_beat.new_qwc),      64'(want.new_qwc));
                compare_field("new_tadr",     64'(out_beat.new_tadr),     64'(want.new_tadr));
                compare_field("new_sadr",     64'(out_beat.new_sadr),     64'(want.new_sadr));
                compare_field("new_chcr",     64'(out_beat.new_chcr),     64'(want.new_chcr));
                compare_field("copy_count",   64'(out_beat.copy_count),   64'(want.copy_count));
                compare_field("copy_src",     64'(out_beat.copy_src),     64'(want.copy_src));
                compare_field("copy_dst",     64'(out_beat.copy_dst),     64'(want.copy_dst));
                compare_field("tag_write",    64'(out_beat.tag_write),    64'(want.tag_write));
                compare_field("tag_used",     64'(out_beat.tag_used),     64'(want.tag_used));
                compare_field("channel_done", 64'(out_beat.channel_done),
                              64'(want.channel_done));
                compare_field("written_back", 64'(out_beat.written_back),
                              64'(want.written_back));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // After reset the controller is disabled, so even a started channel only echoes.
    task automatic test_disabled_echo();
        send_beat(mk_beat(CH_TO_SPR, ctl_word(MODE_CHAIN, 1'b1, 1'b1, 1'b1), 32'h0000_1000,
                          16'd0, 32'h0000_2000, 14'h0010, mk_tag(1'b1, TAG_CNT, 16'd4,
                          32'h0000_3000)));
        send_beat(mk_beat(CH_FROM_SPR, ctl_word(MODE_NORMAL, 1'b0, 1'b0, 1'b1), 32'h8000_0040,
                          16'd8, 32'h0, 14'h0020, '0));
        settle();
    endtask

    // The normal and interleave modes are tested at the count extremes and at the
    // address wrap points. The mode with no transfer, a clear start bit, and
    // all-zero and all-one beats are tested as well.
    task automatic test_plain_modes();
        send_beat(mk_beat(CH_FROM_SPR, ctl_word(MODE_NORMAL, 1'b0, 1'b0, 1'b1), 32'h0000_1000,
                          16'd0, 32'h0, 14'h0000, '0));
        send_beat(mk_beat(CH_TO_SPR, ctl_word(MODE_NORMAL, 1'b1, 1'b1, 1'b1), 32'hFFFF_FFF8,
                          16'd1, 32'h1234_5678, 14'h3FFF, '1));
        send_beat(mk_beat(CH_TO_SPR, ctl_word(MODE_INTERLEAVE, 1'b0, 1'b0, 1'b1), 32'h8000_1230,
                          16'd1025, 32'h0, 14'h0100, '0));
        send_beat(mk_beat(CH_FROM_SPR, ctl_word(MODE_NORMAL, 1'b0, 1'b1, 1'b1), 32'h7FFF_FFFF,
                          16'hFFFF, '1, 14'h2000, '0));
        send_beat(mk_beat(CH_FROM_SPR, ctl_word(MODE_NONE, 1'b0, 1'b0, 1'b1), 32'h0000_4000,
                          16'd12, 32'h0, 14'h0040, '0));
        send_beat(mk_beat(CH_TO_SPR, ctl_word(MODE_CHAIN, 1'b0, 1'b0, 1'b0), 32'h0000_5000,
                          16'd0, 32'h0000_6000, 14'h0080, mk_tag(1'b0, TAG_NEXT, 16'd3,
                          32'h0000_7000)));
        send_beat('1);
        send_beat('0);
        settle();
    endtask

    // Every tag ID is fetched on both channels. The IRQ, interrupt enable and tag
    // transfer bits vary from one fetch to the next. Some addresses lie in the
    // scratchpad window, and the scratchpad address starts close to its wrap point.
    // Counts stay within one chunk, so each channel is free of a pending end again
    // before its next fetch.
    task automatic test_chain_tags();
        logic [2:0]  id;
        logic        ch;
        logic [31:0] tag_addr;
        logic [31:0] tag_ptr;
        for (int n = 0; n < 16; n++) begin
            id       = n[3:1];
            ch       = n[0];
            tag_addr = id[1] ? 32'h8000_0120 : 32'h0040_0008 + n;
            tag_ptr  = id[0] ? 32'h8000_3FF0 : 32'h0002_0000 + (n << 4);
            send_beat(mk_beat(ch, 32'hA5A5_0000 | ctl_word(MODE_CHAIN, id[0], id[1], 1'b1),
                              32'h0100_0000 | n, 16'd0, tag_ptr, 14'h3FF0,
                              mk_tag(id[2] ^ ch, id, {13'h0, id} * 16'd5, tag_addr)));
        end
        settle();
    endtask

    // Random traffic runs in four phases: no idling at all, an idle sender, a
    // stalling receiver, and both sides idling now and then.
    task automatic test_random_traffic();
        run_random(90, 0, 0);
        run_random(90, 55, 0);
        run_random(90, 0, 55);
        run_random(90, 17, 17);
    endtask

    // With the controller disabled in the middle of traffic, every beat echoes and
    // the pending-end bits are left alone.
    task automatic test_enable_off_traffic();
        write_dmac_enable(1'b0);
        run_random(15, 17, 17);
        write_dmac_enable(1'b1);
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering
    // beats, so both pipeline registers fill and the input stalls.
    task automatic test_backpressure();
        idle_pct   = 0;
        stall_pct  = 0;
        hold_armed = 1'b1;
        repeat (30) send_beat(random_beat());
        settle();
    endtask

    initial begin : stimulus
        chan_regs[0] = '0;
        chan_regs[1] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_disabled_echo();
        write_dmac_enable(1'b1);
        test_plain_modes();
        test_chain_tags();
        test_random_traffic();
        test_enable_off_traffic();
        test_backpressure();
        settle();

        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/scdma_pkg.sv
rtl/scdma_step.sv
rtl/scratchpad_dma_channel_step.sv
sim/tb_scratchpad_dma_channel_step.sv
